>>> rtl/core/ikvf_pkg.sv
// Shared types and constants for the infostring key/value finder.
package ikvf_pkg;

  localparam int unsigned MaxKeyChars      = 16;
  localparam int unsigned MaxValueChars    = 255;
  localparam int unsigned KeyTruncateChars = 255;
  localparam int unsigned KeyIdxW          = $clog2(MaxKeyChars);

  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [7:0] NulByte   = 8'h00;

  // Configuration register indexes
  localparam logic [1:0] RegKeyLow  = 2'd0;
  localparam logic [1:0] RegKeyHigh = 2'd1;
  localparam logic [1:0] RegKeyLen  = 2'd2;

  // Result status codes
  localparam logic [1:0] StByte     = 2'd0;
  localparam logic [1:0] StFound    = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_KEY,
    PH_VALUE,
    PH_SKIP,
    PH_DONE
  } phase_t;

  // One result as it travels from the parser to the output stage
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] value_byte;
  } result_t;

endpackage

>>> rtl/core/ikvf_front.sv
// Parser: accepts infostring bytes, tracks key match and produces results.
module ikvf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [63:0]      cfg_data,
  input  logic             accept,
  input  logic [7:0]       text_byte,
  output logic             push,
  output ikvf_pkg::result_t item
);
  import ikvf_pkg::*;

  logic [63:0] key_low;
  logic [63:0] key_high;
  logic [4:0]  key_len;

  phase_t      phase, phase_next;
  logic [7:0]  key_pos, key_pos_next;
  logic        key_match, key_match_next;
  logic [7:0]  value_count, value_count_next;

  logic [MaxKeyChars*8-1:0] key_all;
  logic [7:0]  key_char;
  logic        is_nul;
  logic        is_bs;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      key_len  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        RegKeyLow:  key_low  <= cfg_data;
        RegKeyHigh: key_high <= cfg_data;
        RegKeyLen:  key_len  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign key_all  = {key_high, key_low};
  assign key_char = key_all[key_pos[KeyIdxW-1:0]*8 +: 8];
  assign is_nul   = (text_byte == NulByte);
  assign is_bs    = (text_byte == Backslash);

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      key_pos     <= '0;
      key_match   <= 1'b1;
      value_count <= '0;
    end else begin
      phase       <= phase_next;
      key_pos     <= key_pos_next;
      key_match   <= key_match_next;
      value_count <= value_count_next;
    end
  end

  // Classify the accepted byte and advance the parser
  always_comb begin
    phase_next       = phase;
    key_pos_next     = key_pos;
    key_match_next   = key_match;
    value_count_next = value_count;
    push             = 1'b0;
    item.status      = StNotFound;
    item.value_byte  = '0;
    if (accept) begin
      case (phase)
        PH_LEAD: begin
          if (is_bs) begin
            phase_next       = PH_KEY;
            key_pos_next     = '0;
            key_match_next   = 1'b1;
            value_count_next = '0;
          end else begin
            phase_next = is_nul ? PH_LEAD : PH_DONE;
            push       = 1'b1;
          end
        end
        PH_KEY: begin
          if (is_nul) begin
            phase_next = PH_LEAD;
            push       = 1'b1;
          end else if (is_bs || key_pos >= 8'(KeyTruncateChars)) begin
            if (key_match && key_pos == {3'b000, key_len}) begin
              phase_next       = PH_VALUE;
              value_count_next = '0;
            end else begin
              phase_next = PH_SKIP;
            end
          end else begin
            if (key_pos >= 8'(MaxKeyChars) || text_byte != key_char)
              key_match_next = 1'b0;
            key_pos_next = key_pos + 8'd1;
          end
        end
        PH_VALUE: begin
          push = 1'b1;
          if (is_nul || is_bs || value_count >= 8'(MaxValueChars)) begin
            phase_next  = is_nul ? PH_LEAD : PH_DONE;
            item.status = StFound;
          end else begin
            value_count_next = value_count + 8'd1;
            item.status      = StByte;
            item.value_byte  = text_byte;
          end
        end
        PH_SKIP: begin
          if (is_nul) begin
            phase_next = PH_LEAD;
            push       = 1'b1;
          end else if (is_bs) begin
            phase_next     = PH_KEY;
            key_pos_next   = '0;
            key_match_next = 1'b1;
          end
        end
        default: begin
          if (is_nul) phase_next = PH_LEAD;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/ikvf_queue.sv
// Short result queue between the parser and the output stage.
module ikvf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ikvf_pkg::result_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output ikvf_pkg::result_t head_item
);
  import ikvf_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  result_t         mem [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign full      = (count == CntW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_item = mem[rd_ptr];

  // Store a transfer at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      if (do_pop)
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/ikvf_back.sv
// Output stage: drains the queue into a registered result channel.
module ikvf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  ikvf_pkg::result_t q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [7:0]        value_byte
);
  import ikvf_pkg::*;

  result_t hold;

  // Refill when the register is empty or its transfer completes this cycle
  assign q_pop = q_not_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= q_not_empty;
    end
  end

  // Load payload only on refill so a stalled result holds
  always_ff @(posedge clk) begin
    if (q_pop) hold <= q_item;
  end

  assign status     = hold.status;
  assign value_byte = hold.value_byte;

endmodule

>>> rtl/core/infostring_key_value_finder_core.sv
// Infostring key/value finder: top level joining parser, queue and output stage.
// Scans a backslash-delimited infostring one byte per cycle and returns the
// value bytes of the first key equal to the configured key, then a found
// result, or a single not-found result. A byte is accepted every cycle while
// the result queue (QUEUE_DEPTH entries) has room; the parser works on the
// byte in its cycle of transfer, and a result is written into the queue, then
// loaded into the output register. Sustained rate is one byte per cycle as
// long as the consumer takes results; in_stall rises only when the queue is
// full. Write configuration only while the block is idle.
module infostring_key_value_finder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  value_byte
);
  import ikvf_pkg::*;

  logic    accept;
  logic    push;
  result_t push_item;
  logic    q_full;
  logic    q_pop;
  logic    q_not_empty;
  result_t q_item;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  ikvf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .text_byte (text_byte),
    .push      (push),
    .item      (push_item)
  );

  ikvf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (q_item)
  );

  ikvf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .value_byte  (value_byte)
  );

endmodule
